/* sv/thui_pkg.sv */
// Shared types, codes and reset constants for the thermometer UI controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package thui_pkg;

  localparam int unsigned SupplyW = 12;
  localparam int unsigned TempW   = 12;
  localparam int unsigned TicksW  = 10;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 12;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_LOW_SUPPLY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UNITS_TIMEOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INIT_UNITS    = 2'd3;

  // Register reset values.
  localparam logic [SupplyW-1:0] RST_LOW_SUPPLY    = 12'd1583;
  localparam logic [TicksW-1:0]  RST_IDLE_TIMEOUT  = 10'd300;
  localparam logic [TicksW-1:0]  RST_UNITS_TIMEOUT = 10'd50;
  localparam logic               RST_INIT_UNITS    = 1'b0;

  // Fahrenheit conversion: (9*T + 1600) / 5, with /5 done as a multiply by
  // ceil(2^18 / 5) and a shift by 18, exact for dividends below 2^18.
  localparam logic [15:0] F_OFFSET  = 16'd1600;
  localparam logic [15:0] RECIP5    = 16'd52429;
  localparam int unsigned RECIP_SH  = 18;

  typedef enum logic [10:0] {
    ST_SHOW_TEMP   = 11'b000_0000_0001,
    ST_WAIT_REL    = 11'b000_0000_0010,
    ST_WAIT_BTN    = 11'b000_0000_0100,
    ST_BATT_CHECK  = 11'b000_0000_1000,
    ST_CAPTURE     = 11'b000_0001_0000,
    ST_BATT_LOW    = 11'b000_0010_0000,
    ST_BLANK       = 11'b000_0100_0000,
    ST_SHOW_UNITS  = 11'b000_1000_0000,
    ST_WAIT_UNITS  = 11'b001_0000_0000,
    ST_TOGGLE      = 11'b010_0000_0000,
    ST_WAIT_REL_U  = 11'b100_0000_0000
  } thui_state_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_READY   = 3'd1,
    ACT_NUMBER  = 3'd2,
    ACT_BATT    = 3'd3,
    ACT_BLANK   = 3'd4,
    ACT_UNITS   = 3'd5
  } thui_action_e;

  typedef struct packed {
    logic signed [TempW-1:0]   temp_tenths_c;
    logic        [SupplyW-1:0] supply_code;
    logic                      tick;
    logic                      units_button;
    logic                      measure_button;
  } thui_sample_t;

  typedef struct packed {
    logic                     lcd_enabled;
    logic                     store_units;
    logic                     units_celsius;
    logic signed [ValueW-1:0] display_value;
    logic        [2:0]        display_action;
    logic        [CodeW-1:0]  state_code;
  } thui_result_t;

  typedef struct packed {
    logic [SupplyW-1:0] low_supply_code;
    logic [TicksW-1:0]  idle_timeout_ticks;
    logic [TicksW-1:0]  units_timeout_ticks;
  } thui_cfg_t;

  // Numeric state code as reported on the result channel.
  function automatic logic [CodeW-1:0] state_code(input thui_state_e s);
    logic [CodeW-1:0] c;
    unique case (s)
      ST_SHOW_TEMP:  c = 4'd0;
      ST_WAIT_REL:   c = 4'd1;
      ST_WAIT_BTN:   c = 4'd2;
      ST_BATT_CHECK: c = 4'd3;
      ST_CAPTURE:    c = 4'd4;
      ST_BATT_LOW:   c = 4'd5;
      ST_BLANK:      c = 4'd6;
      ST_SHOW_UNITS: c = 4'd7;
      ST_WAIT_UNITS: c = 4'd8;
      ST_TOGGLE:     c = 4'd9;
      ST_WAIT_REL_U: c = 4'd10;
      default:       c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/thui_conv.sv */
// Converts the held temperature (tenths of a degree C) to tenths of the
// selected unit, rounded to nearest. Depends on thui_pkg.
`default_nettype none

module thui_conv (
  input  wire logic signed [thui_pkg::TempW-1:0]  temp_i,
  input  wire logic                               celsius_i,
  output logic signed      [thui_pkg::ValueW-1:0] value_o
);
  import thui_pkg::*;

  logic signed [15:0] scaled;
  logic               neg;
  logic        [14:0] mag;
  logic        [14:0] biased;
  logic        [30:0] prod;
  logic        [ValueW-1:0] quot;

  always_comb begin
    // 9*T + 1600 stays within 16 signed bits for any 12-bit T.
    scaled = (16'(temp_i) <<< 3) + 16'(temp_i) + $signed(F_OFFSET);
    neg    = scaled[15];
    mag    = neg ? 15'(-scaled) : 15'(scaled);
    // Round half away from zero: (|n| + 2) / 5, sign restored afterwards.
    biased = mag + 15'd2;
    prod   = 31'(biased) * 31'(RECIP5);
    quot   = prod[RECIP_SH +: ValueW];
    if (celsius_i) begin
      value_o = ValueW'(temp_i);
    end else if (neg) begin
      value_o = -$signed(quot);
    end else begin
      value_o = $signed(quot);
    end
  end

endmodule

`default_nettype wire

/* sv/thui_step.sv */
// Controller state and the one-state-per-request step logic: next state,
// timeout counter, units and reading registers, and the combinational result.
// Depends on thui_pkg and thui_conv.
`default_nettype none

module thui_step (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire thui_pkg::thui_sample_t  sample_i,
  input  wire thui_pkg::thui_cfg_t     cfg_i,
  input  wire logic                    units_wr_i,
  input  wire logic                    units_val_i,
  output thui_pkg::thui_result_t       result_o
);
  import thui_pkg::*;

  thui_state_e              state_q, state_d;
  logic [TicksW-1:0]        cnt_q, cnt_d;
  logic                     units_q, units_d;
  logic                     have_q, have_d;
  logic signed [TempW-1:0]  held_q, held_d;
  logic                     disp_q, disp_d;

  logic [TicksW-1:0]        cnt_dec;
  logic                     go;
  thui_state_e              go_state;
  thui_action_e             action;
  logic                     store;
  logic signed [ValueW-1:0] conv_value;

  thui_conv u_conv (
    .temp_i    (held_q),
    .celsius_i (units_q),
    .value_o   (conv_value)
  );

  always_comb begin
    go       = 1'b1;
    go_state = ST_SHOW_TEMP;
    action   = ACT_NONE;
    store    = 1'b0;
    units_d  = units_q;
    have_d   = have_q;
    held_d   = held_q;
    disp_d   = disp_q;
    cnt_dec  = (sample_i.tick && (cnt_q != '0)) ? cnt_q - 1'b1 : cnt_q;
    result_o.display_value = '0;

    unique case (state_q)
      ST_WAIT_REL, ST_WAIT_REL_U: begin
        go       = !sample_i.measure_button && !sample_i.units_button;
        go_state = (state_q == ST_WAIT_REL) ? ST_WAIT_BTN : ST_WAIT_UNITS;
      end
      ST_WAIT_BTN, ST_WAIT_UNITS: begin
        // A tick counts down first; measure outranks units, then timeout.
        if (sample_i.measure_button) begin
          go_state = (state_q == ST_WAIT_BTN) ? ST_BATT_CHECK : ST_SHOW_TEMP;
        end else if (sample_i.units_button) begin
          go_state = (state_q == ST_WAIT_BTN) ? ST_SHOW_UNITS : ST_TOGGLE;
        end else if (cnt_dec == '0) begin
          go_state = (state_q == ST_WAIT_BTN) ? ST_BLANK : ST_SHOW_TEMP;
        end else begin
          go = 1'b0;
        end
      end
      ST_BATT_CHECK: begin
        go_state = (sample_i.supply_code >= cfg_i.low_supply_code) ? ST_BATT_LOW : ST_CAPTURE;
      end
      ST_CAPTURE: begin
        held_d   = sample_i.temp_tenths_c;
        have_d   = 1'b1;
        go_state = ST_SHOW_TEMP;
      end
      ST_BATT_LOW: begin
        disp_d   = 1'b1;
        action   = ACT_BATT;
        go_state = ST_WAIT_REL;
      end
      ST_BLANK: begin
        disp_d   = 1'b0;
        action   = ACT_BLANK;
        go_state = ST_WAIT_BTN;
      end
      ST_SHOW_UNITS: begin
        disp_d   = 1'b1;
        action   = ACT_UNITS;
        go_state = ST_WAIT_REL_U;
      end
      ST_TOGGLE: begin
        units_d  = !units_q;
        store    = 1'b1;
        go_state = ST_SHOW_UNITS;
      end
      default: begin
        disp_d   = 1'b1;
        go_state = ST_WAIT_REL;
        if (have_q) begin
          action                 = ACT_NUMBER;
          result_o.display_value = conv_value;
        end else begin
          action = ACT_READY;
        end
      end
    endcase

    if (go) begin
      state_d = go_state;
      if (go_state == ST_WAIT_BTN) begin
        cnt_d = cfg_i.idle_timeout_ticks;
      end else if (go_state == ST_WAIT_UNITS) begin
        cnt_d = cfg_i.units_timeout_ticks;
      end else begin
        cnt_d = '0;
      end
    end else begin
      state_d = state_q;
      cnt_d   = cnt_dec;
    end

    result_o.state_code     = state_code(state_d);
    result_o.display_action = action;
    result_o.units_celsius  = units_d;
    result_o.store_units    = store;
    result_o.lcd_enabled    = disp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SHOW_TEMP;
      cnt_q   <= '0;
      units_q <= RST_INIT_UNITS;
      have_q  <= 1'b0;
      held_q  <= '0;
      disp_q  <= 1'b0;
    end else if (units_wr_i) begin
      units_q <= units_val_i;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      units_q <= units_d;
      have_q  <= have_d;
      held_q  <= held_d;
      disp_q  <= disp_d;
    end
  end

endmodule

`default_nettype wire

/* sv/thermometer_ui_controller.sv */
// Top level of the thermometer UI controller: stream ports, configuration
// registers, input and result registers. Depends on thui_pkg and thui_step.
//
// Usage. Each request on the slave stream is one sample of the measure and
// units button levels, a 100 ms tick flag, the supply ADC code and the
// temperature in tenths of a degree C. The controller runs the action of its
// current state on that sample and returns exactly one result request on the
// master stream: the new state code, a display action, the number to show
// (nonzero only for the number action), the current units, a store strobe
// when the units were toggled, and whether the LCD is powered.
// An accepted request is held in the input register; its result is loaded into
// the result register when that register is empty or its request is being
// taken. Throughput is one request per cycle unless the receiver stalls; the
// input register and the result register form a two-stage pipeline, and the
// state registers update in the same cycle the result register loads, so
// consecutive samples see each other's state in order. When the receiver
// stalls, the result register holds its request and the input register still
// takes one more sample; after that s_axis_tready drops until the result is
// taken. Reset clears both stages, puts the controller in the show-temperature
// state with no reading held and the display off, and loads the configuration
// registers with their defaults. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so only while no request is in
// flight, which the block does not enforce. Writing the initial units register
// also sets the current units immediately.
`default_nettype none

module thermometer_ui_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Sample requests.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] measure_button, [1] units_button, [2] tick, [14:3] supply_code,
  // [26:15] temp_tenths_c, [31:27] zero
  input  wire logic [31:0] s_axis_tdata,
  // Result requests.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] state_code, [6:4] display_action, [19:7] display_value,
  // [20] units_celsius, [21] store_units, [22] lcd_enabled, [23] zero
  output logic [23:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [thui_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [thui_pkg::CfgDatW-1:0]  cfg_data_i
);
  import thui_pkg::*;

  localparam int unsigned SampleW = $bits(thui_sample_t);
  localparam int unsigned ResultW = $bits(thui_result_t);

  thui_cfg_t    cfg_q;
  logic         units_wr;

  logic         in_vld_q;
  thui_sample_t in_q;
  logic         out_vld_q;
  thui_result_t out_q;
  thui_result_t result;
  logic         advance;

  // The sample moves into the result stage when that stage is empty or its
  // request is being taken in this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  assign units_wr = cfg_we_i && (cfg_idx_i == CFG_INIT_UNITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_supply_code     <= RST_LOW_SUPPLY;
      cfg_q.idle_timeout_ticks  <= RST_IDLE_TIMEOUT;
      cfg_q.units_timeout_ticks <= RST_UNITS_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_SUPPLY:    cfg_q.low_supply_code     <= cfg_data_i[SupplyW-1:0];
        CFG_IDLE_TIMEOUT:  cfg_q.idle_timeout_ticks  <= cfg_data_i[TicksW-1:0];
        CFG_UNITS_TIMEOUT: cfg_q.units_timeout_ticks <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= thui_sample_t'(s_axis_tdata[SampleW-1:0]);
    end
    if (advance) begin
      out_q <= result;
    end
  end

  thui_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .sample_i    (in_q),
    .cfg_i       (cfg_q),
    .units_wr_i  (units_wr),
    .units_val_i (cfg_data_i[0]),
    .result_o    (result)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(24 - ResultW)'(0), out_q};

endmodule

`default_nettype wire

/* tb/thui_display_checker.sv */
// Checker for the thermometer UI controller: follows the sample, result and
// configuration channels, predicts every result request and compares it.
// Depends on thui_pkg for the request layouts, register indexes and actions.
module thui_display_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [23:0]                  m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [thui_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [thui_pkg::CfgDatW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import thui_pkg::*;

  typedef enum logic [CodeW-1:0] {
    UI_SHOW_TEMP   = 4'd0,
    UI_WAIT_REL    = 4'd1,
    UI_WAIT_BTN    = 4'd2,
    UI_BATT_CHECK  = 4'd3,
    UI_CAPTURE     = 4'd4,
    UI_BATT_LOW    = 4'd5,
    UI_BLANK       = 4'd6,
    UI_SHOW_UNITS  = 4'd7,
    UI_WAIT_UNITS  = 4'd8,
    UI_TOGGLE      = 4'd9,
    UI_WAIT_REL_U  = 4'd10
  } ui_state_e;

  // Predicted controller state and its own copy of the registers.
  ui_state_e               ui_state;
  logic [TicksW-1:0]       ticks_left;
  logic                    units_c;
  logic                    have_reading;
  logic                    lcd_on;
  logic signed [TempW-1:0] held_temp;
  logic [SupplyW-1:0]      low_code;
  logic [TicksW-1:0]       idle_ticks;
  logic [TicksW-1:0]       units_ticks;

  thui_result_t expected_displays[$];

  // Entering a wait state loads its timeout; any other state clears the count.
  task automatic enter_state(input ui_state_e nxt);
    ui_state = nxt;
    if (nxt == UI_WAIT_BTN) begin
      ticks_left = idle_ticks;
    end else if (nxt == UI_WAIT_UNITS) begin
      ticks_left = units_ticks;
    end else begin
      ticks_left = '0;
    end
  endtask

  // Tenths of a degree F from tenths of a degree C, rounded half away from zero.
  function automatic logic signed [ValueW-1:0] fahrenheit_tenths(
      input logic signed [TempW-1:0] t);
    int n;
    int q;
    n = 9 * int'(t) + 1600;
    if (n >= 0) begin
      q = (n + 2) / 5;
    end else begin
      q = -((2 - n) / 5);
    end
    return ValueW'(q);
  endfunction

  task automatic predict_display(input thui_sample_t smp, output thui_result_t res);
    thui_action_e            act;
    logic                    store;
    logic signed [ValueW-1:0] val;
    act   = ACT_NONE;
    store = 1'b0;
    val   = '0;
    case (ui_state)
      UI_WAIT_REL, UI_WAIT_REL_U: begin
        if (!smp.measure_button && !smp.units_button) begin
          enter_state(ui_state == UI_WAIT_REL ? UI_WAIT_BTN : UI_WAIT_UNITS);
        end
      end
      UI_WAIT_BTN, UI_WAIT_UNITS: begin
        // The tick counts first, then measure beats units, then the timeout.
        if (smp.tick && ticks_left != 0) begin
          ticks_left = ticks_left - 1'b1;
        end
        if (smp.measure_button) begin
          enter_state(ui_state == UI_WAIT_BTN ? UI_BATT_CHECK : UI_SHOW_TEMP);
        end else if (smp.units_button) begin
          enter_state(ui_state == UI_WAIT_BTN ? UI_SHOW_UNITS : UI_TOGGLE);
        end else if (ticks_left == 0) begin
          enter_state(ui_state == UI_WAIT_BTN ? UI_BLANK : UI_SHOW_TEMP);
        end
      end
      UI_BATT_CHECK: begin
        enter_state(smp.supply_code >= low_code ? UI_BATT_LOW : UI_CAPTURE);
      end
      UI_CAPTURE: begin
        held_temp    = smp.temp_tenths_c;
        have_reading = 1'b1;
        enter_state(UI_SHOW_TEMP);
      end
      UI_BATT_LOW: begin
        lcd_on = 1'b1;
        act    = ACT_BATT;
        enter_state(UI_WAIT_REL);
      end
      UI_BLANK: begin
        lcd_on = 1'b0;
        act    = ACT_BLANK;
        enter_state(UI_WAIT_BTN);
      end
      UI_SHOW_UNITS: begin
        lcd_on = 1'b1;
        act    = ACT_UNITS;
        enter_state(UI_WAIT_REL_U);
      end
      UI_TOGGLE: begin
        units_c = !units_c;
        store   = 1'b1;
        enter_state(UI_SHOW_UNITS);
      end
      default: begin
        lcd_on = 1'b1;
        if (have_reading) begin
          act = ACT_NUMBER;
          if (units_c) begin
            val = held_temp;
          end else begin
            val = fahrenheit_tenths(held_temp);
          end
        end else begin
          act = ACT_READY;
        end
        enter_state(UI_WAIT_REL);
      end
    endcase
    res.state_code     = ui_state;
    res.display_action = act;
    res.display_value  = val;
    res.units_celsius  = units_c;
    res.store_units    = store;
    res.lcd_enabled    = lcd_on;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    thui_result_t want;
    thui_result_t got;
    if (!rst_ni) begin
      low_code     = RST_LOW_SUPPLY;
      idle_ticks   = RST_IDLE_TIMEOUT;
      units_ticks  = RST_UNITS_TIMEOUT;
      units_c      = RST_INIT_UNITS;
      ui_state     = UI_SHOW_TEMP;
      ticks_left   = '0;
      have_reading = 1'b0;
      held_temp    = '0;
      lcd_on       = 1'b0;
      fail_count_o = 0;
      expected_displays.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_SUPPLY:    low_code    = cfg_data_i[SupplyW-1:0];
          CFG_IDLE_TIMEOUT:  idle_ticks  = cfg_data_i[TicksW-1:0];
          CFG_UNITS_TIMEOUT: units_ticks = cfg_data_i[TicksW-1:0];
          CFG_INIT_UNITS:    units_c     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_display(thui_sample_t'(s_axis_tdata[26:0]), want);
        expected_displays.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_displays.size() == 0) begin
          $error("result request with no sample pending: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_displays.pop_front();
          got  = thui_result_t'(m_axis_tdata[22:0]);
          check_field("state_code", want.state_code, got.state_code);
          check_field("display_action", want.display_action, got.display_action);
          check_field("display_value", want.display_value, got.display_value);
          check_field("units_celsius", want.units_celsius, got.units_celsius);
          check_field("store_units", want.store_units, got.store_units);
          check_field("lcd_enabled", want.lcd_enabled, got.lcd_enabled);
          check_field("tdata_pad", 1'b0, m_axis_tdata[23]);
        end
      end
    end
    pending_o = expected_displays.size();
  end

endmodule

/* tb/thermometer_ui_controller_test.sv */
// Stimulus and verdict for the thermometer UI controller; a checker module
// beside the block predicts and compares. Depends on thui_pkg,
// thui_display_checker and thermometer_ui_controller.
module thermometer_ui_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import thui_pkg::*;

  // Random wait before each request, on either side, is drawn up to this.
  localparam int unsigned MaxGap         = 14;
  // One long receiver stall, taken when this many results have been read.
  localparam int unsigned PressureAt     = 300;
  localparam int unsigned PressureCycles = 80;
  // Extra cycles after the last result before a register write or the end,
  // covering the input and result registers with margin.
  localparam int unsigned DrainCycles    = 4;
  // Cycles without any accepted request before the run is declared hung.
  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned Phases         = 7;
  localparam int unsigned ItemsPerPhase  = 78;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [0] measure_button, [1] units_button, [2] tick, [14:3] supply_code,
  // [26:15] temp_tenths_c, [31:27] zero
  logic [31:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [3:0] state_code, [6:4] display_action, [19:7] display_value,
  // [20] units_celsius, [21] store_units, [22] lcd_enabled, [23] zero
  logic [23:0]        m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgDatW-1:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  // Idling limits for the current phase, read by the sender and the receiver.
  int unsigned src_max_gap  = 0;
  int unsigned sink_max_gap = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  thermometer_ui_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  thui_display_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic thui_sample_t make_sample(input logic meas, input logic unit,
      input logic tick, input logic [SupplyW-1:0] supply,
      input logic signed [TempW-1:0] temp);
    thui_sample_t smp;
    smp.measure_button = meas;
    smp.units_button   = unit;
    smp.tick           = tick;
    smp.supply_code    = supply;
    smp.temp_tenths_c  = temp;
    return smp;
  endfunction

  // Random sample. Buttons are pressed now and then so that the wait states
  // see releases, presses and runs of ticks long enough to time out. The
  // supply code often sits right at the low battery threshold.
  function automatic thui_sample_t random_sample(input logic [SupplyW-1:0] low);
    thui_sample_t smp;
    int           near;
    smp.measure_button = ($urandom_range(0, 4) == 0);
    smp.units_button   = ($urandom_range(0, 4) == 0);
    smp.tick           = ($urandom_range(0, 9) < 6);
    case ($urandom_range(0, 3))
      0: begin
        near = int'(low) - 1 + int'($urandom_range(0, 2));
        if (near < 0) near = 0;
        if (near > 4095) near = 4095;
        smp.supply_code = SupplyW'(near);
      end
      1: smp.supply_code = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      default: smp.supply_code = SupplyW'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      smp.temp_tenths_c = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
    end else begin
      smp.temp_tenths_c = TempW'($urandom);
    end
    return smp;
  endfunction

  // Offers one sample request after a random wait and returns at the edge
  // where it is accepted. The valid stays high between back-to-back requests.
  task automatic send_sample(input thui_sample_t smp);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, smp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Writes all four registers on consecutive edges. The unused upper data
  // bits of the narrow registers carry random junk that must be ignored.
  task automatic write_config(input logic [SupplyW-1:0] low,
      input logic [TicksW-1:0] idle, input logic [TicksW-1:0] units,
      input logic init_c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOW_SUPPLY;
    cfg_data_i <= low;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDLE_TIMEOUT;
    cfg_data_i <= {2'($urandom), idle};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNITS_TIMEOUT;
    cfg_data_i <= {2'($urandom), units};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INIT_UNITS;
    cfg_data_i <= {11'($urandom), init_c};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Called in the step of the last acceptance, so the first edge below comes
  // after the checker has recorded that request.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Result side: a random wait before each request, and once a long stall
  // while the sender keeps offering, so both pipeline stages fill and the
  // block has to drop s_axis_tready.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, sink_max_gap);
      if (results_taken == PressureAt) gap = PressureCycles;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  // Hang detection: any accepted request on either stream resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SupplyW-1:0] low;
    logic [TicksW-1:0]  idle;
    logic [TicksW-1:0]  units;
    logic               init_c;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through every state with one-tick timeouts, threshold
    // 2000 and Fahrenheit units. Covers the ready mark with no reading, a
    // held button in the release wait, the idle timeout blanking the display,
    // battery low above and exactly at the threshold, a good battery just
    // below it, capture of the coldest temperature shown in F, measure
    // winning over units when both are pressed, the units screen, a toggle
    // with its store strobe, the units timeout and the reading shown in C.
    write_config(12'd2000, 10'd1, 10'd1, 1'b0);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b1, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b1, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b1, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd4095, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b1, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd1999, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sh800));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b1, 1'b1, 1'b1, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd2000, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b1, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b1, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b1, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b1, 12'd0, 12'sd0));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 12'd0, 12'sd0));
    wait_all_results();

    // Random phases. The first few use fixed settings: the reset values, the
    // largest registers, zero registers (every code low, waits that time out
    // on their first step) and the smallest legal values. The rest draw short
    // timeouts so that timeouts happen often. Writing the initial units also
    // reloads the current units, so each phase starts from a known unit.
    for (int unsigned phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: begin
          low = RST_LOW_SUPPLY; idle = RST_IDLE_TIMEOUT;
          units = RST_UNITS_TIMEOUT; init_c = RST_INIT_UNITS;
        end
        1: begin
          low = 12'd4095; idle = 10'd1023; units = 10'd1023; init_c = 1'b1;
        end
        2: begin
          low = 12'd0; idle = 10'd0; units = 10'd0; init_c = 1'b0;
        end
        3: begin
          low = 12'd1; idle = 10'd1; units = 10'd1; init_c = 1'b1;
        end
        default: begin
          low    = SupplyW'($urandom_range(1, 4095));
          idle   = TicksW'($urandom_range(1, 12));
          units  = TicksW'($urandom_range(1, 12));
          init_c = 1'($urandom);
        end
      endcase
      write_config(low, idle, units, init_c);
      // Phases alternate between idling sides and back-to-back traffic; the
      // long receiver stall lands in phase 3, where the sender never idles.
      src_max_gap  = (phase % 3 == 0) ? 0 : MaxGap;
      sink_max_gap = (phase % 2 == 1) ? 0 : MaxGap;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        send_sample(random_sample(low));
      end
      wait_all_results();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
